### rtl/srlh_pkg.sv
// ============================================================================
// srlh_pkg
// Shared types and constants for the slow request log with day histogram
// ============================================================================
package srlh_pkg;

    localparam int LOG_DEPTH = 256;
    localparam int MAX_DAYS  = 32;
    localparam int MAX_BINS  = 96;
    localparam int SLOT_W    = $clog2(LOG_DEPTH);
    localparam int DAY_W     = $clog2(MAX_DAYS);
    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int CNT_ADDR_W = $clog2(MAX_DAYS * MAX_BINS);
    localparam int CNT_DEPTH = MAX_DAYS * MAX_BINS;
    localparam int LEN_W     = SLOT_W + 1;
    localparam int ENTRY_W   = 48 + 40 + 40 + 8;
    localparam int CFG_W     = 41;
    localparam int CFG_IDX_W = 2;

    localparam logic [47:0] ID_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ACT_RECORD = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_READ_E = 2'd2,
        ACT_READ_B = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_THRESH = 2'd0,
        CFG_CAP    = 2'd1,
        CFG_MODE   = 2'd2,
        CFG_DAYS   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR,
        ST_BUMP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]  action;
        logic [39:0] duration_us;
        logic [7:0]  command_kind;
        logic [39:0] timestamp_s;
        logic [7:0]  year_since_1900;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [7:0]  entry_position;
        logic [4:0]  days_back;
        logic [6:0]  bin_number;
    } t_req;

    typedef struct packed {
        logic        logged;
        logic [47:0] entry_id;
        logic [8:0]  log_length;
        logic        read_valid;
        logic [39:0] read_duration;
        logic [7:0]  read_command_kind;
        logic [39:0] read_timestamp;
        logic [7:0]  read_year;
        logic [3:0]  read_month;
        logic [4:0]  read_day;
        logic [31:0] bin_count;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic latch;     // capture request, issue reads
        logic exec;      // apply update, decide rollover
        logic clr_step;  // clear one bin of new day
        logic bump;      // write incremented bin
        logic out_load;  // result register load
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_clear;
        logic need_bump;
        logic clr_last;
    } t_sts;

endpackage

### rtl/srlh_if.sv
// ============================================================================
// srlh_if
// Valid/ready channel carrying one payload
// ============================================================================
interface srlh_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/srlh_ram.sv
// ============================================================================
// srlh_ram
// Generic single-port-write, one-read RAM with registered read
// ============================================================================
module srlh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

### rtl/srlh_ctrl.sv
// ============================================================================
// srlh_ctrl
// Sequencer: accept, execute, optional day clear and bin bump, deliver
// ============================================================================
module srlh_ctrl import srlh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_EXEC;
            ST_EXEC: begin
                if (i_sts.need_clear)     n_state = ST_CLEAR;
                else if (i_sts.need_bump) n_state = ST_BUMP;
                else                      n_state = ST_OUT;
            end
            ST_CLEAR: if (i_sts.clr_last) n_state = i_sts.need_bump ? ST_BUMP : ST_OUT;
            ST_BUMP:  n_state = ST_OUT;
            ST_OUT:   if (i_out_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.latch  = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                o_cmd.out_load = 1'b1;
            end
            ST_CLEAR: o_cmd.clr_step = 1'b1;
            ST_BUMP:  o_cmd.bump = 1'b1;
            ST_OUT:   o_out_valid = 1'b1;
            default: ;
        endcase
    end

    a_one_hs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("in and out open together");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("result dropped");
    a_exec_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.latch |=> o_cmd.exec) else $error("exec missing");
endmodule

### rtl/srlh_dp.sv
// ============================================================================
// srlh_dp
// Datapath: log ring, day ring, bin counter memory and result register
// ============================================================================
module srlh_dp import srlh_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_req                 i_req,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output t_rsp                 o_rsp
);
    // configuration
    logic [40:0] r_thresh;
    logic [8:0]  r_cap;
    logic [2:0]  r_mode;
    logic [5:0]  r_days;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= '1;
            r_cap    <= 9'd256;
            r_mode   <= '0;
            r_days   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESH: r_thresh <= i_cfg_data;
                CFG_CAP:    r_cap    <= i_cfg_data[8:0];
                CFG_MODE:   r_mode   <= i_cfg_data[2:0];
                CFG_DAYS:   r_days   <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // derived config
    logic [6:0] w_bins;
    logic [5:0] w_dk;
    logic [8:0] w_cap;
    always_comb begin
        case (r_mode)
            3'd1: w_bins = 7'd12;
            3'd2: w_bins = 7'd24;
            3'd3: w_bins = 7'd48;
            3'd4: w_bins = 7'd96;
            default: w_bins = 7'd0;
        endcase
        w_dk  = (r_days > 6'(MAX_DAYS)) ? 6'(MAX_DAYS) : r_days;
        w_cap = (r_cap == 9'd0) ? 9'd1 : (r_cap > 9'(LOG_DEPTH) ? 9'(LOG_DEPTH) : r_cap);
    end

    // control state
    logic [SLOT_W-1:0] r_newest;
    logic [LEN_W-1:0]  r_held;
    logic [47:0]       r_next_id;
    logic [DAY_W-1:0]  r_cur;
    logic [MAX_DAYS-1:0] r_dvalid;
    logic [7:0]        r_dyear [MAX_DAYS];
    logic [3:0]        r_dmon  [MAX_DAYS];
    logic [4:0]        r_ddate [MAX_DAYS];
    t_req              r_req;
    logic [DAY_W-1:0]  r_rday;
    logic              r_rday_ok;
    logic              r_need_clear, r_need_bump;
    logic [DAY_W-1:0]  r_bday;
    logic [BIN_W-1:0]  r_bidx;
    logic [BIN_W-1:0]  r_clr;
    t_rsp              r_rsp;

    // read slot and day
    logic [SLOT_W-1:0] w_rslot;
    logic [5:0]        w_dsum;
    logic [DAY_W-1:0]  w_rday;
    always_comb begin
        w_rslot = r_newest - SLOT_W'(i_req.entry_position);
        w_dsum  = ({1'b0, r_cur} >= 6'(i_req.days_back))
                ? 6'({1'b0, r_cur} - 6'(i_req.days_back))
                : 6'({1'b0, r_cur} + w_dk - 6'(i_req.days_back));
        w_rday  = w_dsum[DAY_W-1:0];
    end

    // bin index of a record
    logic [7:0] w_idx;
    logic [1:0] w_q;
    always_comb begin
        w_q = (r_req.minute >= 6'd45) ? 2'd3 : (r_req.minute >= 6'd30) ? 2'd2 :
              (r_req.minute >= 6'd15) ? 2'd1 : 2'd0;
        case (w_bins)
            7'd12:   w_idx = 8'(r_req.hour >> 1);
            7'd24:   w_idx = 8'(r_req.hour);
            7'd48:   w_idx = {2'b0, r_req.hour, (r_req.minute >= 6'd30)};
            default: w_idx = {1'b0, r_req.hour, w_q};
        endcase
    end

    // memories
    logic [ENTRY_W-1:0] w_ent_rd;
    logic [31:0]        w_cnt_rd;
    logic               w_ent_we, w_cnt_we;
    logic [ENTRY_W-1:0] w_ent_wd;
    logic [CNT_ADDR_W-1:0] w_cnt_wa, w_cnt_ra;
    logic [31:0]        w_cnt_wd;
    logic [31:0]        w_cnt_base;

    function automatic logic [CNT_ADDR_W-1:0] f_addr(input logic [DAY_W-1:0] d,
                                                      input logic [BIN_W-1:0] b);
        logic [CNT_ADDR_W+7:0] p;
        p = (CNT_ADDR_W+8)'(d) * (CNT_ADDR_W+8)'(MAX_BINS) + (CNT_ADDR_W+8)'(b);
        return p[CNT_ADDR_W-1:0];
    endfunction

    srlh_ram #(.WIDTH(ENTRY_W), .DEPTH(LOG_DEPTH)) u_log (
        .i_clk, .i_we(w_ent_we), .i_waddr(r_newest + SLOT_W'(1)), .i_wdata(w_ent_wd),
        .i_raddr(w_rslot), .o_rdata(w_ent_rd));

    srlh_ram #(.WIDTH(32), .DEPTH(CNT_DEPTH)) u_cnt (
        .i_clk, .i_we(w_cnt_we), .i_waddr(w_cnt_wa), .i_wdata(w_cnt_wd),
        .i_raddr(w_cnt_ra), .o_rdata(w_cnt_rd));

    // exec decisions
    logic w_rec, w_stat, w_dmatch, w_dempty;
    logic w_need_clear, w_need_bump;
    logic [DAY_W-1:0] w_nday;
    always_comb begin
        w_rec    = (t_action'(r_req.action) == ACT_RECORD) && !r_thresh[40] &&
                   ({1'b0, r_req.duration_us} >= r_thresh);
        w_stat   = (w_bins != 7'd0) && (w_dk != 6'd0);
        w_dempty = !r_dvalid[r_cur] || (r_dyear[r_cur] == 8'd0);
        w_dmatch = (r_dyear[r_cur] == r_req.year_since_1900) &&
                   (r_dmon[r_cur] == r_req.month) &&
                   (r_ddate[r_cur] == r_req.day_of_month);
        w_nday   = (6'(r_cur) + 6'd1 >= w_dk) ? '0 : r_cur + DAY_W'(1);
        // a day never used since reset is zeroed before its first count
        w_need_clear = w_rec && w_stat && (!r_dvalid[r_cur] || !(w_dempty || w_dmatch));
        w_need_bump  = w_rec && w_stat && (w_idx < 8'(w_bins));
    end

    // bump base is the bin read during exec, or zero after a clear
    always_comb begin
        w_cnt_base = r_need_clear ? 32'd0 : w_cnt_rd;
        w_ent_we = i_cmd.exec && w_rec;
        w_ent_wd = {r_next_id, r_req.duration_us, r_req.timestamp_s, r_req.command_kind};
        w_cnt_we = i_cmd.clr_step || i_cmd.bump;
        w_cnt_wa = f_addr(r_bday, i_cmd.bump ? r_bidx : r_clr);
        w_cnt_wd = i_cmd.bump ? ((w_cnt_base == CNT_MAX) ? w_cnt_base : w_cnt_base + 32'd1)
                              : '0;
        w_cnt_ra = i_cmd.latch ? f_addr(w_rday, BIN_W'(i_req.bin_number))
                               : f_addr(r_cur, w_idx[BIN_W-1:0]);
    end

    // sequencing of state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= '0; r_held <= '0; r_next_id <= '0; r_cur <= '0;
            r_dvalid <= '0; r_need_clear <= 1'b0; r_need_bump <= 1'b0;
            r_clr <= '0;
        end else begin
            if (i_cmd.latch) begin
                r_req     <= i_req;
                r_rday    <= w_rday;
                r_rday_ok <= (w_bins != 7'd0) && (6'(i_req.days_back) < w_dk) &&
                             (w_dsum < 6'(MAX_DAYS));
            end
            if (i_cmd.exec) begin
                r_need_clear <= w_need_clear;
                r_need_bump  <= w_need_bump;
                case (t_action'(r_req.action))
                    ACT_RECORD: if (w_rec) begin
                        r_newest <= r_newest + SLOT_W'(1);
                        if (r_next_id != ID_MAX) r_next_id <= r_next_id + 48'd1;
                        if (9'(r_held) < w_cap) r_held <= r_held + LEN_W'(1);
                        if (w_stat) begin
                            r_bidx <= w_idx[BIN_W-1:0];
                            r_clr  <= '0;
                            if (w_dempty || w_dmatch) begin
                                r_bday <= r_cur;
                                r_dvalid[r_cur] <= 1'b1;
                                r_dyear[r_cur] <= r_req.year_since_1900;
                                r_dmon[r_cur]  <= r_req.month;
                                r_ddate[r_cur] <= r_req.day_of_month;
                            end else begin
                                r_bday <= w_nday;
                                r_cur  <= w_nday;
                                r_dvalid[w_nday] <= 1'b1;
                                r_dyear[w_nday] <= r_req.year_since_1900;
                                r_dmon[w_nday]  <= r_req.month;
                                r_ddate[w_nday] <= r_req.day_of_month;
                            end
                        end
                    end
                    ACT_CLEAR: r_held <= '0;
                    default: ;
                endcase
            end
            if (i_cmd.clr_step) r_clr <= r_clr + BIN_W'(1);
        end
    end

    // result register
    logic [LEN_W-1:0] w_len;
    t_rsp             w_rsp;
    always_comb begin
        w_len = r_held;
        if (t_action'(r_req.action) == ACT_CLEAR) w_len = '0;
        else if (w_rec && 9'(r_held) < w_cap) w_len = r_held + LEN_W'(1);
    end

    always_comb begin
        w_rsp = '0;
        w_rsp.log_length = 9'(w_len);
        case (t_action'(r_req.action))
            ACT_RECORD: if (w_rec) begin
                w_rsp.logged   = 1'b1;
                w_rsp.entry_id = r_next_id;
            end
            ACT_READ_E: if (9'(r_req.entry_position) < 9'(r_held)) begin
                w_rsp.read_valid        = 1'b1;
                w_rsp.entry_id          = w_ent_rd[135:88];
                w_rsp.read_duration     = w_ent_rd[87:48];
                w_rsp.read_timestamp    = w_ent_rd[47:8];
                w_rsp.read_command_kind = w_ent_rd[7:0];
            end
            ACT_READ_B: if (r_rday_ok && r_dvalid[r_rday] && r_dyear[r_rday] != 8'd0) begin
                w_rsp.read_valid = 1'b1;
                w_rsp.read_year  = r_dyear[r_rday];
                w_rsp.read_month = r_dmon[r_rday];
                w_rsp.read_day   = r_ddate[r_rday];
                if (r_req.bin_number < w_bins) w_rsp.bin_count = w_cnt_rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) r_rsp <= w_rsp;
    end

    // status is live during exec, held afterwards
    assign o_sts.need_clear = i_cmd.exec ? w_need_clear : r_need_clear;
    assign o_sts.need_bump  = i_cmd.exec ? w_need_bump : r_need_bump;
    assign o_sts.clr_last   = (r_clr == BIN_W'(MAX_BINS - 1));
    assign o_rsp = r_rsp;

    a_clr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_step |-> r_clr < BIN_W'(MAX_BINS)) else $error("clear past day");
    a_held_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= LEN_W'(LOG_DEPTH)) else $error("log length overflow");
    a_bump_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.bump |-> r_bidx < BIN_W'(MAX_BINS)) else $error("bin index overflow");
endmodule

### rtl/slow_request_log_with_histogram_unit.sv
// ============================================================================
// slow_request_log_with_histogram_unit
// Slow request log ring with per-day request histogram
// ============================================================================
// channel | dir | payload
// req     | in  | t_req (action, request, local time, read selectors)
// rsp     | out | t_rsp (one result per request)
// cfg     | in  | i_cfg_we / i_cfg_idx / i_cfg_data
//
// An item passes through the accept, execute and result states, the last
// being the result beat; a record that bumps a bin adds a bump state, and a
// day rollover or the first use of a day after reset adds a clear state that
// zeroes the day's bins in turn via the bin counter RAM's single write port.
// Reset is synchronous active low; no clearing pass, a day's bins are zeroed
// when the day is first used.
// A stalled result holds the block; no new request is taken until it leaves.
module slow_request_log_with_histogram_unit import srlh_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    srlh_if.sink                 req,
    srlh_if.source               rsp
);
    t_cmd w_cmd;
    t_sts w_sts;

    srlh_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(req.valid), .o_in_ready(req.ready),
        .o_out_valid(rsp.valid), .i_out_ready(rsp.ready),
        .i_sts(w_sts), .o_cmd(w_cmd));

    srlh_dp u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_req(req.data), .i_cmd(w_cmd), .o_sts(w_sts), .o_rsp(rsp.data));
endmodule
